// File: hdl/edat_pkg.sv
// shared constants, types and helpers for the edge drawing anchor tracer
package edat_pkg;

	// image and queue geometry
	localparam int IMG_W        = 128;
	localparam int IMG_H        = 128;
	localparam int ANCHOR_DEPTH = 1024;

	localparam int XW   = $clog2(IMG_W);
	localparam int YW   = $clog2(IMG_H);
	localparam int NPIX = IMG_W * IMG_H;
	localparam int AW   = $clog2(NPIX);
	localparam int QW   = XW + YW;
	localparam int QAW  = $clog2(ANCHOR_DEPTH);
	localparam int CNTW = $clog2(ANCHOR_DEPTH + 1);
	localparam int MW   = (XW > YW) ? XW : YW;
	localparam int CW   = ((MW > 7) ? MW : 7) + 2;

	// field widths
	localparam int OPC_W   = 2;
	localparam int PXW     = 7;
	localparam int MAGW    = 8;
	localparam int TOTAL_W = 11;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 8;
	localparam int SKIP_W  = 4;

	// register reset values
	localparam logic [MAGW-1:0]   GTHR_RST = 8'd36;
	localparam logic [MAGW-1:0]   ATHR_RST = 8'd8;
	localparam logic [SKIP_W-1:0] SKIP_RST = 4'd3;

	// register indexes
	localparam logic [CFG_IW-1:0] REG_GRAD_THR  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_ANCH_THR  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_SCAN_SKIP = 2'd2;

	// opcodes
	localparam logic [OPC_W-1:0] OPC_LOAD = 2'd0;
	localparam logic [OPC_W-1:0] OPC_RUN  = 2'd1;
	localparam logic [OPC_W-1:0] OPC_READ = 2'd2;

	typedef logic signed [CW-1:0] coord_t;

	// datapath commands
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RD_EDGE,
		OP_RESP,
		OP_ACK,
		OP_CLR_INIT,
		OP_CLR,
		OP_SC_C,
		OP_SC_A,
		OP_SC_B,
		OP_SC_E,
		OP_Q_RD,
		OP_Q_LD,
		OP_Q_CHK,
		OP_T_RD,
		OP_T_TEST,
		OP_T_L,
		OP_T_M,
		OP_T_H,
		OP_T_SEL
	} dp_op_t;

	// datapath status back to the controller
	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic q_more;
		logic anchor_ok;
		logic trace_cont;
		logic sense_pos;
	} dp_status_t;

	function automatic logic in_img(input coord_t x, input coord_t y);
		in_img = !x[CW-1] && !y[CW-1] && (x < coord_t'(IMG_W)) && (y < coord_t'(IMG_H));
	endfunction

	function automatic logic [AW-1:0] lin_addr(input coord_t x, input coord_t y);
		lin_addr = AW'(y[YW-1:0]) * AW'(IMG_W) + AW'(x[XW-1:0]);
	endfunction

endpackage

// File: hdl/edat_ctrl.sv
// controller state machine sequencing load, read, clear, scan and trace
module edat_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [edat_pkg::OPC_W-1:0]  opcode,
	input  edat_pkg::dp_status_t        status,
	output edat_pkg::dp_op_t            op,
	output logic                        busy
);
	import edat_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR, ST_RESP,
		ST_SC_C, ST_SC_A, ST_SC_B, ST_SC_E,
		ST_Q_RD, ST_Q_LD, ST_Q_CHK,
		ST_T_RD, ST_T_TEST, ST_T_L, ST_T_M, ST_T_H, ST_T_SEL
	} state_t;

	state_t state_q;
	logic   run_q;
	logic   busy_q;

	assign busy = busy_q;

	// command for the current state
	always_comb begin
		op = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (opcode)
						OPC_LOAD: op = OP_LOAD;
						OPC_RUN:  op = OP_CLR_INIT;
						OPC_READ: op = OP_RD_EDGE;
						default:  op = OP_ACK;
					endcase
				end
			end
			ST_CLR:    op = OP_CLR;
			ST_RESP:   op = OP_RESP;
			ST_SC_C:   op = OP_SC_C;
			ST_SC_A:   op = OP_SC_A;
			ST_SC_B:   op = OP_SC_B;
			ST_SC_E:   op = OP_SC_E;
			ST_Q_RD:   op = status.q_more ? OP_Q_RD : OP_ACK;
			ST_Q_LD:   op = OP_Q_LD;
			ST_Q_CHK:  op = OP_Q_CHK;
			ST_T_RD:   op = OP_T_RD;
			ST_T_TEST: op = OP_T_TEST;
			ST_T_L:    op = OP_T_L;
			ST_T_M:    op = OP_T_M;
			ST_T_H:    op = OP_T_H;
			ST_T_SEL:  op = OP_T_SEL;
			default:   op = OP_NONE;
		endcase
	end

	// state and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			run_q   <= 1'b0;
			busy_q  <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (opcode == OPC_RUN) begin
							state_q <= ST_CLR;
							run_q   <= 1'b1;
							busy_q  <= 1'b1;
						end else if (opcode == OPC_READ) begin
							state_q <= ST_RESP;
							busy_q  <= 1'b1;
						end
					end
				end
				ST_CLR: begin
					if (status.clr_last) begin
						if (run_q) begin
							state_q <= ST_SC_C;
						end else begin
							state_q <= ST_IDLE;
							busy_q  <= 1'b0;
						end
					end
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				ST_SC_C: state_q <= ST_SC_A;
				ST_SC_A: state_q <= ST_SC_B;
				ST_SC_B: state_q <= ST_SC_E;
				ST_SC_E: state_q <= status.scan_last ? ST_Q_RD : ST_SC_C;
				ST_Q_RD: begin
					if (status.q_more) begin
						state_q <= ST_Q_LD;
					end else begin
						state_q <= ST_IDLE;
						run_q   <= 1'b0;
						busy_q  <= 1'b0;
					end
				end
				ST_Q_LD:  state_q <= ST_Q_CHK;
				ST_Q_CHK: state_q <= status.anchor_ok ? ST_T_RD : ST_Q_RD;
				ST_T_RD:  state_q <= ST_T_TEST;
				ST_T_TEST: begin
					if (status.trace_cont)
						state_q <= ST_T_L;
					else if (status.sense_pos)
						state_q <= ST_Q_RD;
					else
						state_q <= ST_T_RD;
				end
				ST_T_L:   state_q <= ST_T_M;
				ST_T_M:   state_q <= ST_T_H;
				ST_T_H:   state_q <= ST_T_SEL;
				ST_T_SEL: state_q <= ST_T_RD;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/edat_dp.sv
// datapath: gradient, edge and anchor memories, coordinates, counters, results
module edat_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  edat_pkg::dp_op_t              op,
	output edat_pkg::dp_status_t          status,
	input  logic [edat_pkg::PXW-1:0]      pixel_x,
	input  logic [edat_pkg::PXW-1:0]      pixel_y,
	input  logic [edat_pkg::MAGW-1:0]     grad_magnitude,
	input  logic                          grad_direction,
	input  logic                          cfg_we,
	input  logic [edat_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [edat_pkg::CFG_DW-1:0]   cfg_data,
	output logic                          done,
	output logic                          edge_bit,
	output logic                          anchor_overflow,
	output logic [edat_pkg::TOTAL_W-1:0]  anchor_total
);
	import edat_pkg::*;

	// memories
	logic [MAGW:0]   pix_mem  [NPIX];
	logic            edge_mem [NPIX];
	logic [QW-1:0]   q_mem    [ANCHOR_DEPTH];

	// control registers
	logic [MAGW-1:0]   gthr_q, athr_q;
	logic [SKIP_W-1:0] skip_q;
	logic              done_q, ovf_q;
	logic [CNTW-1:0]   cnt_q, qi_q;
	logic [AW-1:0]     clr_q;

	// payload registers
	logic [MAGW:0]   pix_rd_q;
	logic            mark_rd_q, in_q, edge_bit_q;
	logic [QW-1:0]   qdata_q;
	coord_t          sx_q, sy_q, cx_q, cy_q, ax_q, ay_q;
	logic [MAGW-1:0] v_q, a_q, lo_q, mid_q;
	logic            sd_q, d_q, s_pos_q, forced_q;

	// read address and derived values
	coord_t          rx, ry, in_x, in_y, qx, qy;
	logic            r_in, w_in;
	logic [AW-1:0]   raddr;
	logic [MAGW-1:0] rmag, eff;
	logic            rdir, marked, cont, hit, push, e_we, e_wd;
	logic [AW-1:0]   e_waddr;
	logic [QW-1:0]   push_val;
	logic [MAGW:0]   sum_a, sum_b;
	coord_t          sy_next;

	assign in_x = coord_t'(pixel_x);
	assign in_y = coord_t'(pixel_y);
	assign qx   = coord_t'(qdata_q[XW-1:0]);
	assign qy   = coord_t'(qdata_q[QW-1:XW]);
	assign w_in = in_img(in_x, in_y);

	// read address select
	always_comb begin
		rx = cx_q;
		ry = cy_q;
		case (op)
			OP_RD_EDGE: begin rx = in_x; ry = in_y; end
			OP_SC_C:    begin rx = sx_q; ry = sy_q; end
			OP_SC_A: begin
				if (rdir) begin rx = sx_q - coord_t'(1); ry = sy_q; end
				else begin rx = sx_q; ry = sy_q - coord_t'(1); end
			end
			OP_SC_B: begin
				if (sd_q) begin rx = sx_q + coord_t'(1); ry = sy_q; end
				else begin rx = sx_q; ry = sy_q + coord_t'(1); end
			end
			OP_Q_LD: begin rx = qx; ry = qy; end
			OP_T_L: begin
				if (d_q) begin rx = cx_q - coord_t'(1); ry = cy_q; end
				else begin rx = cx_q; ry = cy_q - coord_t'(1); end
			end
			OP_T_H: begin
				if (d_q) begin rx = cx_q + coord_t'(1); ry = cy_q; end
				else begin rx = cx_q; ry = cy_q + coord_t'(1); end
			end
			default: begin rx = cx_q; ry = cy_q; end
		endcase
	end

	assign r_in  = in_img(rx, ry);
	assign raddr = r_in ? lin_addr(rx, ry) : '0;

	// read beat decoding with threshold
	assign rmag   = pix_rd_q[MAGW-1:0];
	assign rdir   = pix_rd_q[MAGW];
	assign eff    = (in_q && (rmag > gthr_q)) ? rmag : '0;
	assign marked = in_q & mark_rd_q;
	assign cont   = forced_q || ((eff != '0) && (rdir == d_q) && !marked);

	// anchor test on the scan row
	assign sum_a = {1'b0, v_q} - {1'b0, v_q} + {1'b0, a_q} + {1'b0, athr_q};
	assign sum_b = {1'b0, eff} + {1'b0, athr_q};
	assign hit   = (sum_a <= {1'b0, v_q}) && (sum_b <= {1'b0, v_q});

	// anchor push
	assign push = ((op == OP_SC_E) && hit) ||
	              ((op == OP_T_TEST) && !cont && (eff != '0) && !marked);
	assign push_val = (op == OP_SC_E) ? {sy_q[YW-1:0], sx_q[XW-1:0]}
	                                  : {cy_q[YW-1:0], cx_q[XW-1:0]};

	// edge map write
	assign e_we    = (op == OP_CLR) || ((op == OP_T_TEST) && cont && in_q);
	assign e_wd    = (op == OP_T_TEST);
	assign e_waddr = (op == OP_CLR) ? clr_q : lin_addr(cx_q, cy_q);

	assign sy_next = sy_q + coord_t'(skip_q) + coord_t'(1);

	// status
	assign status.clr_last   = (clr_q == AW'(NPIX - 1));
	assign status.scan_last  = (sx_q == coord_t'(IMG_W - 2)) &&
	                           (sy_next >= coord_t'(IMG_H - 1));
	assign status.q_more     = (qi_q < cnt_q);
	assign status.anchor_ok  = (eff != '0) && !marked;
	assign status.trace_cont = cont;
	assign status.sense_pos  = s_pos_q;

	assign done            = done_q;
	assign edge_bit        = edge_bit_q;
	assign anchor_overflow = ovf_q;
	assign anchor_total    = TOTAL_W'(cnt_q);

	// gradient map
	always_ff @(posedge clk) begin
		if ((op == OP_LOAD) && w_in)
			pix_mem[lin_addr(in_x, in_y)] <= {grad_direction, grad_magnitude};
		pix_rd_q <= pix_mem[raddr];
	end

	// edge map
	always_ff @(posedge clk) begin
		if (e_we)
			edge_mem[e_waddr] <= e_wd;
		mark_rd_q <= edge_mem[raddr];
	end

	// anchor queue
	always_ff @(posedge clk) begin
		if (push && (cnt_q < CNTW'(ANCHOR_DEPTH)))
			q_mem[cnt_q[QAW-1:0]] <= push_val;
		qdata_q <= q_mem[qi_q[QAW-1:0]];
	end

	// configuration, counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gthr_q <= GTHR_RST;
			athr_q <= ATHR_RST;
			skip_q <= SKIP_RST;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			qi_q   <= '0;
			clr_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GRAD_THR:  gthr_q <= cfg_data;
					REG_ANCH_THR:  athr_q <= cfg_data;
					REG_SCAN_SKIP: skip_q <= cfg_data[SKIP_W-1:0];
					default: ;
				endcase
			end
			done_q <= (op == OP_LOAD) || (op == OP_RESP) || (op == OP_ACK);
			if (push) begin
				if (cnt_q < CNTW'(ANCHOR_DEPTH))
					cnt_q <= cnt_q + CNTW'(1);
				else
					ovf_q <= 1'b1;
			end
			case (op)
				OP_CLR_INIT: begin
					clr_q <= '0;
					cnt_q <= '0;
					ovf_q <= 1'b0;
					qi_q  <= '0;
				end
				OP_CLR: clr_q <= clr_q + AW'(1);
				OP_Q_CHK: if (!status.anchor_ok) qi_q <= qi_q + CNTW'(1);
				OP_T_TEST: if (!cont && s_pos_q) qi_q <= qi_q + CNTW'(1);
				default: ;
			endcase
		end
	end

	// coordinates, trace state and sample registers
	always_ff @(posedge clk) begin
		in_q <= r_in;
		case (op)
			OP_LOAD, OP_ACK: edge_bit_q <= 1'b0;
			OP_RESP: edge_bit_q <= marked;
			OP_CLR_INIT: begin
				sx_q <= coord_t'(1);
				sy_q <= coord_t'(1);
			end
			OP_SC_A: begin
				v_q  <= eff;
				sd_q <= rdir;
			end
			OP_SC_B: a_q <= eff;
			OP_SC_E: begin
				if (sx_q == coord_t'(IMG_W - 2)) begin
					sx_q <= coord_t'(1);
					sy_q <= sy_next;
				end else begin
					sx_q <= sx_q + coord_t'(1);
				end
			end
			OP_Q_LD: begin
				cx_q <= qx;
				cy_q <= qy;
			end
			OP_Q_CHK: begin
				d_q      <= rdir;
				s_pos_q  <= 1'b0;
				forced_q <= 1'b0;
				ax_q     <= cx_q;
				ay_q     <= cy_q;
			end
			OP_T_TEST: begin
				if (cont) begin
					// mark and step forward
					forced_q <= 1'b0;
					if (!d_q)
						cx_q <= s_pos_q ? cx_q + coord_t'(1) : cx_q - coord_t'(1);
					else
						cy_q <= s_pos_q ? cy_q + coord_t'(1) : cy_q - coord_t'(1);
				end else if (!s_pos_q) begin
					// second sense leaves the anchor with one forced step
					cx_q     <= ax_q;
					cy_q     <= ay_q;
					s_pos_q  <= 1'b1;
					forced_q <= 1'b1;
				end
			end
			OP_T_M: lo_q  <= eff;
			OP_T_H: mid_q <= eff;
			OP_T_SEL: begin
				// strongest forward neighbor, straight on ties
				if ((lo_q > mid_q) && (lo_q > eff)) begin
					if (!d_q) cy_q <= cy_q - coord_t'(1);
					else cx_q <= cx_q - coord_t'(1);
				end else if ((eff > mid_q) && (eff > lo_q)) begin
					if (!d_q) cy_q <= cy_q + coord_t'(1);
					else cx_q <= cx_q + coord_t'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// File: hdl/edge_drawing_anchor_trace.sv
// top level of the edge drawing anchor tracer
// An item is taken at a clock edge with start high and busy low; its result is
// shown for one cycle with done high and cannot be held off. A load leaves busy
// low and the next item may follow at once; a read keeps busy high for one
// cycle, its edge map read is registered as it is taken and its result with
// done in ST_RESP. A run first clears the edge map at one entry a cycle (all
// IMG_W*IMG_H entries, 16384 here), then scans the anchor rows through ST_SC_C
// to ST_SC_E per pixel, takes each queued anchor through ST_Q_RD to ST_Q_CHK
// and each traced pixel through ST_T_RD to ST_T_SEL, with an extra read and
// test at each end of a traced anchor, and ends with a last ST_Q_RD; the single
// read port of both maps sets these steps. After reset the same clearing pass
// runs with busy high; configuration writes are taken at any time.
module edge_drawing_anchor_trace (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [edat_pkg::OPC_W-1:0]    opcode,
	input  logic [edat_pkg::PXW-1:0]      pixel_x,
	input  logic [edat_pkg::PXW-1:0]      pixel_y,
	input  logic [edat_pkg::MAGW-1:0]     grad_magnitude,
	input  logic                          grad_direction,
	input  logic                          cfg_we,
	input  logic [edat_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [edat_pkg::CFG_DW-1:0]   cfg_data,
	output logic                          done,
	output logic                          edge_bit,
	output logic                          anchor_overflow,
	output logic [edat_pkg::TOTAL_W-1:0]  anchor_total
);
	import edat_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	// controller
	edat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	// datapath
	edat_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.status          (status),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.grad_magnitude  (grad_magnitude),
		.grad_direction  (grad_direction),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.done            (done),
		.edge_bit        (edge_bit),
		.anchor_overflow (anchor_overflow),
		.anchor_total    (anchor_total)
	);

endmodule
